[rtl/ufbp_pkg.sv]
// ----------------------------------------------------------------------------
// ufbp_pkg
// shared widths, parity codes and framing helpers for the frame bit packer
// ----------------------------------------------------------------------------
package ufbp_pkg;

    localparam int DATA_W     = 8;
    localparam int MODE_W     = 2;
    localparam int FRAME_BITS = 11;
    localparam int PEND_W     = 7;
    localparam int CNT_W      = 3;
    localparam int ACC_W      = PEND_W + FRAME_BITS;

    localparam logic [MODE_W-1:0] PAR_NONE = 2'd0;
    localparam logic [MODE_W-1:0] PAR_EVEN = 2'd1;
    localparam logic [MODE_W-1:0] PAR_ODD  = 2'd2;

    localparam logic [1:0] STOP_PAIR = 2'b11;
    localparam logic       START_BIT = 1'b0;

    // parity over bits 0..6 placed in bit 7, other modes pass the byte
    function automatic logic [DATA_W-1:0] apply_parity(
        input logic [DATA_W-1:0] b,
        input logic [MODE_W-1:0] mode
    );
        logic [DATA_W-1:0] res;
        res = b;
        if (mode == PAR_EVEN) begin
            res = {^b[6:0], b[6:0]};
        end else if (mode == PAR_ODD) begin
            res = {~^b[6:0], b[6:0]};
        end
        return res;
    endfunction

    // start bit, data lsb first, two stop bits; earliest bit in the msb
    function automatic logic [FRAME_BITS-1:0] make_frame(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] rev;
        for (int i = 0; i < DATA_W; i++) begin
            rev[DATA_W-1-i] = b[i];
        end
        return {START_BIT, rev, STOP_PAIR};
    endfunction

endpackage

[rtl/ufbp_if.sv]
// ----------------------------------------------------------------------------
// ufbp interfaces
// valid/ready channels for input items, stream bytes and the config write
// ----------------------------------------------------------------------------
interface ufbp_in_if
    import ufbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              flush;

    modport source (output valid, output data_byte, output flush, input ready);
    modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

interface ufbp_out_if
    import ufbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] stream_byte;
    logic              last;

    modport source (output valid, output stream_byte, output last, input ready);
    modport sink   (input valid, input stream_byte, input last, output ready);
endinterface

interface ufbp_cfg_if
    import ufbp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/uart_frame_bit_packer.sv]
// ----------------------------------------------------------------------------
// uart_frame_bit_packer
// frames bytes as 11-bit async frames and packs them msb first into bytes
// ----------------------------------------------------------------------------
//  channel   dir  payload                   transaction
//  i_in      in   data_byte[7:0], flush     one byte to frame, or end of stream
//  o_out     out  stream_byte[7:0], last    one packed stream byte
//  i_cfg     in   data[1:0]                 parity_mode write, always ready
//
//  - a transaction on i_in is packed in the cycle it is taken; its zero,
//    one or two bytes land in a two-entry output queue
//  - o_out moves one byte per cycle while o_out.ready is high; the
//    queue depth and the single output channel set this rate
//  - i_in is ready when the queue is empty or its last byte leaves this cycle
//  - synchronous active-low reset clears parity_mode, the bit accumulator and
//    the queue
//  - stalls on o_out hold the queue and, through ready, the input side
// ----------------------------------------------------------------------------
module uart_frame_bit_packer
    import ufbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ufbp_in_if.sink    i_in,
    ufbp_out_if.source o_out,
    ufbp_cfg_if.sink   i_cfg
);

    // configuration and accumulator state
    logic [MODE_W-1:0] r_mode;
    logic [PEND_W-1:0] r_pend_bits, n_pend_bits;
    logic [CNT_W-1:0]  r_pend_cnt, n_pend_cnt;

    // output queue, entry 0 is the head
    logic [DATA_W-1:0] r_q_byte [2];
    logic [1:0]        r_q_last;
    logic [1:0]        r_q_cnt;

    logic              in_acc;
    logic              out_pop;
    logic [1:0]        res_num;
    logic [DATA_W-1:0] res_byte0, res_byte1;
    logic              res_last0;

    // packing datapath
    logic [ACC_W-1:0]  acc;
    logic [3:0]        shift_hi;
    logic [CNT_W-1:0]  shift_lo;
    logic [DATA_W-1:0] keep_mask;
    logic [14:0]       flush_wide;
    logic              two_bytes;

    assign i_cfg.ready = 1'b1;

    assign out_pop     = o_out.valid & o_out.ready;
    assign o_out.valid = (r_q_cnt != 2'd0);
    assign o_out.stream_byte = r_q_byte[0];
    assign o_out.last  = r_q_last[0];

    // room once the queue is empty or is emptying now
    assign i_in.ready = (r_q_cnt == 2'd0) || ((r_q_cnt == 2'd1) && o_out.ready);
    assign in_acc     = i_in.valid & i_in.ready;

    always_comb begin
        acc        = {r_pend_bits, make_frame(apply_parity(i_in.data_byte, r_mode))};
        two_bytes  = (r_pend_cnt >= CNT_W'(5));
        // first byte starts at the oldest pending bit
        shift_hi   = 4'({1'b0, r_pend_cnt} + 4'd3);
        shift_lo   = r_pend_cnt - CNT_W'(5);
        flush_wide = 15'({8'd0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt}));

        res_byte0  = 8'(acc >> shift_hi);
        res_byte1  = 8'(acc >> shift_lo);
        res_last0  = 1'b1;
        res_num    = 2'd1;
        n_pend_cnt = two_bytes ? shift_lo : CNT_W'(shift_hi);

        if (i_in.flush) begin
            // pending bits left-aligned, zero padded
            res_byte0  = flush_wide[7:0];
            res_num    = (r_pend_cnt != '0) ? 2'd1 : 2'd0;
            n_pend_cnt = '0;
        end else if (two_bytes) begin
            res_last0 = 1'b0;
            res_num   = 2'd2;
        end

        keep_mask   = 8'((9'd1 << n_pend_cnt) - 9'd1);
        n_pend_bits = i_in.flush ? '0 : (acc[PEND_W-1:0] & keep_mask[PEND_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= PAR_NONE;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_q_cnt     <= 2'd0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.data;
            end
            if (in_acc) begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
                r_q_cnt     <= res_num;
            end else if (out_pop) begin
                r_q_cnt <= r_q_cnt - 2'd1;
            end
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q_byte[0] <= res_byte0;
            r_q_byte[1] <= res_byte1;
            r_q_last    <= {1'b1, res_last0};
        end else if (out_pop) begin
            r_q_byte[0] <= r_q_byte[1];
            r_q_last[0] <= r_q_last[1];
        end
    end

    // queue never holds more than two bytes
    a_q_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("output queue overflow");

    // a data transaction always leaves at least one byte queued
    a_data_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.flush) |=> (r_q_cnt != 2'd0))
        else $error("data item produced no byte");

    // a flush empties the accumulator
    a_flush_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.flush) |=> (r_pend_cnt == '0 && r_pend_bits == '0))
        else $error("flush left pending bits");

    // with two bytes queued only the second is marked last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt == 2'd2) |-> (r_q_last == 2'b10))
        else $error("wrong last marking");

    // no stray bits above the pending count
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_bits >> r_pend_cnt) == '0)
        else $error("stray accumulator bits");

endmodule
